### rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg: shared types, codes and CRC helpers
// Phase codes, item and result structs, and the CRC-8 step functions used by
// the single-wire backlight master.
// ----------------------------------------------------------------------------
package owbm_pkg;

  // Session phases
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PRE  = 3'd1,
    PH_LOW  = 3'd2,
    PH_TX   = 3'd3,
    PH_HOLD = 3'd4,
    PH_RX   = 3'd5,
    PH_TAIL = 3'd6
  } phase_t;

  // Item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_MAX_ATTEMPTS   = 1'b0;
  localparam logic CFG_PREAMBLE_TICKS = 1'b1;
  localparam int   CFG_DATA_W         = 7;

  // Register reset values
  localparam logic [2:0] MAX_ATTEMPTS_RST   = 3'd3;
  localparam logic [6:0] PREAMBLE_TICKS_RST = 7'd60;

  // Protocol constants
  localparam logic [7:0] CRC_INIT      = 8'hAC;
  localparam logic [7:0] CRC_POLY      = 8'h07;
  localparam logic [7:0] REQ_FLAG      = 8'h80;
  localparam logic [6:0] BRIGHT_MAX    = 7'd127;
  localparam logic [6:0] LOW_TICKS     = 7'd2;
  localparam logic [6:0] TX_BITS       = 7'd16;
  localparam int         RX_SHIFT_W    = 32;
  localparam int         RESP_DATA_W   = 24;
  localparam int         RESPONSE_BITS_DEF = 32;

  // One input word
  typedef struct packed {
    logic       kind;
    logic [7:0] brightness;
    logic       line_sample;
  } item_t;

  // One result word
  typedef struct packed {
    logic        drive_enable;
    logic        drive_level;
    logic        busy_res;
    logic        rejected;
    logic        done_res;
    logic        success;
    logic [23:0] response_data;
  } result_t;

  // Advance the CRC by one message bit, MSB first
  function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic b);
    logic [7:0] r;
    r = {crc[6:0], 1'b0};
    if (crc[7] ^ b) begin
      r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  // CRC of one byte from the initial value
  function automatic logic [7:0] crc8_byte(input logic [7:0] data);
    logic [7:0] crc;
    crc = CRC_INIT;
    for (int i = 7; i >= 0; i--) begin
      crc = crc8_bit(crc, data[i]);
    end
    return crc;
  endfunction

  // CRC after n leading zero bits (elaboration-time only)
  function automatic logic [7:0] crc8_zeros(input int n);
    logic [7:0] crc;
    crc = CRC_INIT;
    for (int i = 0; i < RX_SHIFT_W; i++) begin
      if (i < n) begin
        crc = crc8_bit(crc, 1'b0);
      end
    end
    return crc;
  endfunction

endpackage

### rtl/owbm_session.sv
// ----------------------------------------------------------------------------
// owbm_session: session sequencer of the single-wire master
// Holds the session state, advances it by one word on each step and forms
// the result word from the state after that step.
// ----------------------------------------------------------------------------
module owbm_session #(
  parameter int RESPONSE_BITS = owbm_pkg::RESPONSE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  owbm_pkg::item_t  item,
  input  logic [2:0]       max_attempts,
  input  logic [6:0]       preamble_ticks,
  output owbm_pkg::result_t res
);

  // Response bits that enter the check CRC, and the CRC after the zero pad
  localparam logic [6:0] RESP_BITS_W = 7'(RESPONSE_BITS);
  localparam logic [6:0] DATA_BITS_W = 7'(RESPONSE_BITS - 8);
  localparam logic [7:0] RX_CRC_INIT =
    owbm_pkg::crc8_zeros(owbm_pkg::RX_SHIFT_W - RESPONSE_BITS);

  owbm_pkg::phase_t phase, phase_next;
  logic [6:0]  tick_count, tick_count_next;
  logic [15:0] transmit_shift, transmit_shift_next;
  logic [31:0] receive_shift, receive_shift_next;
  logic [2:0]  attempt_count, attempt_count_next;
  logic [7:0]  rx_crc, rx_crc_next;

  logic        rej, done, ok;
  logic [6:0]  tick_inc;
  logic [2:0]  attempt_inc;
  logic [2:0]  limit;
  logic [6:0]  bright_sat;
  logic [7:0]  req;
  logic        en, lvl;

  assign tick_inc    = tick_count + 7'd1;
  assign attempt_inc = attempt_count + 3'd1;
  assign limit       = (max_attempts == 3'd0) ? 3'd1 : max_attempts;
  assign bright_sat  = item.brightness[7] ? owbm_pkg::BRIGHT_MAX : item.brightness[6:0];
  assign req         = {1'b0, bright_sat} | owbm_pkg::REQ_FLAG;

  // Next state
  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    transmit_shift_next = transmit_shift;
    receive_shift_next  = receive_shift;
    attempt_count_next  = attempt_count;
    rx_crc_next         = rx_crc;
    rej  = 1'b0;
    done = 1'b0;
    ok   = 1'b0;
    if (item.kind == owbm_pkg::KIND_START) begin
      if (phase != owbm_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        transmit_shift_next = {req, owbm_pkg::crc8_byte(req)};
        attempt_count_next  = 3'd0;
        phase_next          = owbm_pkg::PH_PRE;
        tick_count_next     = 7'd0;
        receive_shift_next  = '0;
        rx_crc_next         = RX_CRC_INIT;
      end
    end else begin
      case (phase)
        owbm_pkg::PH_IDLE: begin
        end
        owbm_pkg::PH_PRE: begin
          if (tick_inc >= preamble_ticks) begin
            phase_next      = owbm_pkg::PH_LOW;
            tick_count_next = 7'd0;
          end else begin
            tick_count_next = tick_inc;
          end
        end
        owbm_pkg::PH_LOW: begin
          if (tick_inc >= owbm_pkg::LOW_TICKS) begin
            phase_next      = owbm_pkg::PH_TX;
            tick_count_next = 7'd0;
          end else begin
            tick_count_next = tick_inc;
          end
        end
        owbm_pkg::PH_TX: begin
          if (tick_inc >= owbm_pkg::TX_BITS) begin
            phase_next      = owbm_pkg::PH_HOLD;
            tick_count_next = 7'd0;
          end else begin
            tick_count_next = tick_inc;
          end
        end
        owbm_pkg::PH_HOLD: begin
          phase_next      = owbm_pkg::PH_RX;
          tick_count_next = 7'd0;
        end
        owbm_pkg::PH_RX: begin
          // Shift in the sample; the CRC sees only the data bits
          receive_shift_next = {receive_shift[30:0], item.line_sample};
          if (tick_count < DATA_BITS_W) begin
            rx_crc_next = owbm_pkg::crc8_bit(rx_crc, item.line_sample);
          end
          if (tick_inc >= RESP_BITS_W) begin
            phase_next      = owbm_pkg::PH_TAIL;
            tick_count_next = 7'd0;
          end else begin
            tick_count_next = tick_inc;
          end
        end
        owbm_pkg::PH_TAIL: begin
          tick_count_next = 7'd0;
          if (rx_crc == receive_shift[7:0]) begin
            done       = 1'b1;
            ok         = 1'b1;
            phase_next = owbm_pkg::PH_IDLE;
          end else begin
            attempt_count_next = attempt_inc;
            if (attempt_inc >= limit) begin
              done       = 1'b1;
              phase_next = owbm_pkg::PH_IDLE;
            end else begin
              // Retry: run the session again
              phase_next         = owbm_pkg::PH_PRE;
              receive_shift_next = '0;
              rx_crc_next        = RX_CRC_INIT;
            end
          end
        end
        default: begin
          phase_next = owbm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Line drive after the step
  always_comb begin
    en  = 1'b1;
    lvl = 1'b1;
    case (phase_next)
      owbm_pkg::PH_LOW: begin
        lvl = 1'b0;
      end
      owbm_pkg::PH_TX: begin
        lvl = transmit_shift_next[~tick_count_next[3:0]];
      end
      owbm_pkg::PH_HOLD: begin
        lvl = transmit_shift_next[0];
      end
      owbm_pkg::PH_RX, owbm_pkg::PH_TAIL: begin
        en  = 1'b0;
        lvl = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Result word
  always_comb begin
    res.drive_enable  = en;
    res.drive_level   = lvl;
    res.busy_res      = (phase_next != owbm_pkg::PH_IDLE);
    res.rejected      = rej;
    res.done_res      = done;
    res.success       = ok;
    res.response_data = receive_shift_next[31:8];
  end

  // Session state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= owbm_pkg::PH_IDLE;
      tick_count     <= 7'd0;
      transmit_shift <= '0;
      receive_shift  <= '0;
      attempt_count  <= 3'd0;
      rx_crc         <= owbm_pkg::CRC_INIT;
    end else if (step) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      transmit_shift <= transmit_shift_next;
      receive_shift  <= receive_shift_next;
      attempt_count  <= attempt_count_next;
      rx_crc         <= rx_crc_next;
    end
  end

endmodule

### rtl/one_wire_backlight_master_core.sv
// ----------------------------------------------------------------------------
// one_wire_backlight_master_core: tick-driven single-wire backlight master
// Flow: a word accepted on s_* is held in the input register, then stepped and
// loaded into the m_* register once the output slot is free.
// Throughput: one word per cycle unless m_tready stalls the output; the step
// is a single pass of logic between the input register and the output register.
// Reset: synchronous rst returns the session to idle (line driven high),
// max_attempts to 3 and preamble_ticks to 60; no clearing pass.
// ----------------------------------------------------------------------------
module one_wire_backlight_master_core #(
  parameter int RESPONSE_BITS = owbm_pkg::RESPONSE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] brightness, [8] line_sample, rest zero
  input  logic        s_tuser,   // [0] kind
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [0] drive_enable, [1] drive_level, [2] busy_res,
                                 // [3] rejected, [4] done_res, [5] success,
                                 // [29:6] response_data, rest zero
);

  logic [2:0]        max_attempts;
  logic [6:0]        preamble_ticks;
  logic              in_valid;
  owbm_pkg::item_t   in_item;
  logic              advance;
  owbm_pkg::result_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts   <= owbm_pkg::MAX_ATTEMPTS_RST;
      preamble_ticks <= owbm_pkg::PREAMBLE_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        owbm_pkg::CFG_MAX_ATTEMPTS:   max_attempts   <= cfg_data[2:0];
        owbm_pkg::CFG_PREAMBLE_TICKS: preamble_ticks <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Move the input word forward whenever the output slot is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind        <= s_tuser;
      in_item.brightness  <= s_tdata[7:0];
      in_item.line_sample <= s_tdata[8];
    end
  end

  owbm_session #(
    .RESPONSE_BITS(RESPONSE_BITS)
  ) u_session (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (in_item),
    .max_attempts  (max_attempts),
    .preamble_ticks(preamble_ticks),
    .res           (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {2'b00, res.response_data, res.success, res.done_res, res.rejected,
                  res.busy_res, res.drive_level, res.drive_enable};
    end
  end

endmodule

### rtl/owbm_checker.sv
// ----------------------------------------------------------------------------
// owbm_checker: port-level checks of the single-wire master
// Watches the result stream for stalls and for flag combinations that the
// session sequencer must never produce.
// ----------------------------------------------------------------------------
module owbm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Success only comes with done, and done ends the session
  a_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[5] || m_tdata[4]) |-> m_tdata[4] && !m_tdata[2])
    else $error("success without done or done while busy");

  // Reject a start only while a session runs
  a_rej: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> m_tdata[2])
    else $error("start rejected while idle");

  // Drive the line high when idle
  a_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[0] && m_tdata[1])
    else $error("line not driven high while idle");

endmodule

bind one_wire_backlight_master_core owbm_checker u_owbm_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);
